// ===== rtl/core/fsvr_pkg.sv =====
package fsvr_pkg;

  localparam int ID_BITS    = 16;
  localparam int COUNT_BITS = 32;
  localparam int MAP_DEPTH  = 1 << ID_BITS;

  typedef logic [ID_BITS-1:0]    id_t;
  typedef logic [ID_BITS:0]      id_count_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // one map entry: seen flag plus the dense id given to that vertex
  typedef struct packed {
    logic seen;
    id_t  id;
  } map_entry_t;

  localparam int ENTRY_BITS = $bits(map_entry_t);

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_DELETE  = 2'd1,
    KIND_BREAK   = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_EMIT    = 2'd0,
    STATUS_BREAK   = 2'd1,
    STATUS_ERROR   = 2'd2,
    STATUS_IGNORED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SRC   = 4'b0100,
    ST_DST   = 4'b1000
  } state_t;

endpackage

// ===== rtl/core/first_seen_vertex_renumber.sv =====
// Flow: the src read resolves and the dst read issues in ST_SRC, then the dst read resolves and
//   the output register loads in ST_DST, which waits while the held output is not taken.
// Each request makes two dependent reads of the single map RAM; the next may enter in its dst step.
// Reset: synchronous, active high; clears counters and halt flag, then runs a clearing pass
//   over all 2^ID_BITS entries of the map RAM, with in_ready low for its duration.
module first_seen_vertex_renumber
  import fsvr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] src_vertex,
  input  logic [15:0] dst_vertex,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [15:0] new_src,
  output logic [15:0] new_dst,
  output logic [1:0]  status,
  output logic [31:0] updates_emitted,
  output logic [16:0] vertices_assigned
);

  // control state
  state_t    state, state_next;
  id_t       clr_addr;
  logic      halted, halted_next;
  id_count_t next_free, next_free_next;
  count_t    update_total, update_total_next;

  // request held while it walks the map
  logic [1:0] kind_q;
  id_t        src_q;
  id_t        dst_q;
  id_t        src_id, src_id_next;

  // map RAM ports
  logic       ram_we, ram_re;
  id_t        ram_waddr, ram_raddr;
  map_entry_t ram_wdata, ram_rdata, rd_ent;

  // write that landed in the same cycle as the outstanding read
  logic       fwd_hit;
  map_entry_t fwd_data;

  logic accept, out_free, out_load, emit;
  id_t  dst_id;
  status_t out_status;

  fsvr_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid || out_ready;
  // new request is taken in IDLE, or overlapped with the dst step of the previous one when the output is free
  assign in_ready = (state == ST_IDLE) || ((state == ST_DST) && out_free);
  assign accept   = in_valid && in_ready;
  assign out_load = (state == ST_DST) && out_free;

  // halted cannot change between the src and dst steps of one request
  assign emit   = !halted && ((kind_q == KIND_INSERT) || (kind_q == KIND_DELETE));
  assign rd_ent = fwd_hit ? fwd_data : ram_rdata;

  always_comb begin
    state_next        = state;
    halted_next       = halted;
    next_free_next    = next_free;
    update_total_next = update_total;
    src_id_next       = src_id;
    dst_id            = '0;
    out_status        = STATUS_EMIT;
    ram_we            = 1'b0;
    ram_waddr         = clr_addr;
    ram_wdata         = '0;
    ram_re            = 1'b0;
    ram_raddr         = id_t'(src_vertex);

    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (&clr_addr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          ram_re     = 1'b1;
          state_next = ST_SRC;
        end
      end
      ST_SRC: begin
        // source first, so a self-loop sees its own id through the forward path
        ram_re     = 1'b1;
        ram_raddr  = dst_q;
        state_next = ST_DST;
        if (emit) begin
          if (rd_ent.seen) begin
            src_id_next = rd_ent.id;
          end else begin
            src_id_next    = id_t'(next_free);
            ram_we         = 1'b1;
            ram_waddr      = src_q;
            ram_wdata.seen = 1'b1;
            ram_wdata.id   = id_t'(next_free);
            if (!next_free[ID_BITS]) begin
              next_free_next = next_free + 1'b1;
            end
          end
        end
      end
      ST_DST: begin
        if (out_load) begin
          priority if (halted) begin
            out_status = STATUS_IGNORED;
          end else if (kind_q == KIND_BREAK) begin
            out_status  = STATUS_BREAK;
            halted_next = 1'b1;
          end else if (kind_q == KIND_UNKNOWN) begin
            out_status  = STATUS_ERROR;
            halted_next = 1'b1;
          end else begin
            out_status = STATUS_EMIT;
            if (!(&update_total)) begin
              update_total_next = update_total + 1'b1;
            end
            if (rd_ent.seen) begin
              dst_id = rd_ent.id;
            end else begin
              dst_id         = id_t'(next_free);
              ram_we         = 1'b1;
              ram_waddr      = dst_q;
              ram_wdata.seen = 1'b1;
              ram_wdata.id   = id_t'(next_free);
              if (!next_free[ID_BITS]) begin
                next_free_next = next_free + 1'b1;
              end
            end
          end
          if (accept) begin
            ram_re     = 1'b1;
            state_next = ST_SRC;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      halted       <= 1'b0;
      next_free    <= '0;
      update_total <= '0;
      out_valid    <= 1'b0;
      fwd_hit      <= 1'b0;
    end else begin
      state        <= state_next;
      halted       <= halted_next;
      next_free    <= next_free_next;
      update_total <= update_total_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // RAM reads old data on a same-cycle write to the same entry
      if (ram_re) begin
        fwd_hit <= ram_we && (ram_waddr == ram_raddr);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ram_re) begin
      fwd_data <= ram_wdata;
    end
    if (accept) begin
      kind_q <= kind;
      src_q  <= id_t'(src_vertex);
      dst_q  <= id_t'(dst_vertex);
    end
    src_id <= src_id_next;
    if (out_load) begin
      out_kind          <= (out_status == STATUS_EMIT) ? kind_q[0] : 1'b0;
      new_src           <= (out_status == STATUS_EMIT) ? 16'(src_id) : 16'd0;
      new_dst           <= 16'(dst_id);
      status            <= out_status;
      updates_emitted   <= 32'(update_total_next);
      vertices_assigned <= 17'(next_free_next);
    end
  end

  // assertions
  a_load_from_dst: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DST))
    else $error("output loaded outside the dst step");

  a_src_then_dst: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRC) |=> (state == ST_DST))
    else $error("src step not followed by dst step");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    !next_free[ID_BITS] || (next_free[ID_BITS-1:0] == '0))
    else $error("next free id beyond map depth");

  a_emit_not_halted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STATUS_EMIT)) |-> !halted)
    else $error("emitted result pending while halted");

endmodule

// ===== rtl/core/fsvr_ram.sv =====
module fsvr_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
